[hw/rtl/sem_pkg.sv]
// Package for the segment extent map: sizes, block codes, command codes,
// controller states and the transaction and control structs.
// No dependencies; every other file of the block but sem_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package sem_pkg;

    localparam int BLOCKS      = 128;
    localparam int WORD_BLOCKS = 16;
    localparam int BLK_W       = $clog2(BLOCKS);
    localparam int CNT_W       = $clog2(BLOCKS + 1);
    localparam int WB_W        = $clog2(WORD_BLOCKS);
    localparam int WORD_N      = BLOCKS / WORD_BLOCKS;
    localparam int WORD_AW     = $clog2(WORD_N);
    localparam int WORD_DW     = 2 * WORD_BLOCKS;

    localparam logic [1:0] CODE_EMPTY  = 2'd0;
    localparam logic [1:0] CODE_END    = 2'd1;
    localparam logic [1:0] CODE_START  = 2'd2;
    localparam logic [1:0] CODE_INSIDE = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_HEAD,
        ST_MOD
    } state_t;

    typedef struct packed {
        logic       op;
        logic [6:0] offset;
        logic [7:0] len;
    } item_t;

    typedef struct packed {
        logic [1:0] block_code;
        logic       head_trimmed;
        logic       tail_trimmed;
        logic [7:0] written_count;
    } result_t;

    typedef struct packed {
        logic [BLK_W-1:0] first;
        logic [BLK_W-1:0] prev;
        logic [BLK_W-1:0] last;
        logic [BLK_W-1:0] after;
        logic             has_prev;
        logic             has_after;
        logic             head_ok;
    } upd_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/sem_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sem_ram #(
    parameter int ADDR_W = 3,
    parameter int DATA_W = 32
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/sem_word_upd.sv]
// Rewrites one packed word of block codes for an insert: marks the run and
// trims the neighboring segments. Depends on sem_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sem_word_upd (
    input  wire sem_pkg::upd_ctl_t             ctl,
    input  wire logic [sem_pkg::WORD_AW-1:0]   word,
    input  wire logic [sem_pkg::WORD_DW-1:0]   old_word,
    output logic      [sem_pkg::WORD_DW-1:0]   new_word,
    output logic                               head_hit,
    output logic                               tail_hit
);
    import sem_pkg::*;

    always_comb
    begin
        logic [BLK_W-1:0] b;
        logic [1:0]       c;
        new_word = old_word;
        head_hit = 1'b0;
        tail_hit = 1'b0;
        for (int j = 0; j < WORD_BLOCKS; j++)
        begin
            b = {word, WB_W'(j)};
            c = old_word[2*j +: 2];
            if (b >= ctl.first && b <= ctl.last)
            begin
                if (b == ctl.first)
                begin
                    new_word[2*j +: 2] = CODE_START;
                end
                else if (b == ctl.last)
                begin
                    new_word[2*j +: 2] = CODE_END;
                end
                else
                begin
                    new_word[2*j +: 2] = CODE_INSIDE;
                end
            end
            else if (ctl.has_prev && ctl.head_ok && b == ctl.prev && c == CODE_INSIDE)
            begin
                new_word[2*j +: 2] = CODE_END;
                head_hit = 1'b1;
            end
            else if (ctl.has_after && b == ctl.after && (c == CODE_INSIDE || c == CODE_END))
            begin
                new_word[2*j +: 2] = CODE_START;
                tail_hit = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/segment_extent_map_insert.sv]
// A read passes through ST_READ before its result is shown; a zero-length insert is answered
// straight from idle; any other insert passes ST_HEAD, then ST_MOD for each word of
// 16 blocks it touches, and its result is registered on the last word.
// Throughput: one word is read and rewritten per cycle through the RAM's two ports.
// A new transaction is taken in the cycle its predecessor's result is shown.
// Reset clears the per-word valid bits, so the whole map reads empty at once.
`timescale 1ns / 1ps
`default_nettype none

module segment_extent_map_insert (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire sem_pkg::item_t  cmd,
    output logic                 done,
    output sem_pkg::result_t     result
);
    import sem_pkg::*;

    state_t              state_reg, state_next;
    logic                done_reg, done_next;
    result_t             result_reg, result_next;
    logic [WORD_N-1:0]   valid_reg;
    logic                rvalid_reg;
    logic [BLK_W-1:0]    first_reg, first_next;
    logic [BLK_W-1:0]    prev_reg, prev_next;
    logic [BLK_W-1:0]    last_reg, last_next;
    logic [BLK_W-1:0]    after_reg, after_next;
    logic                has_prev_reg, has_prev_next;
    logic                has_after_reg, has_after_next;
    logic                head_ok_reg, head_ok_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [WORD_AW-1:0]  word_reg, word_next;
    logic [WORD_AW-1:0]  wend_reg, wend_next;
    logic                head_acc_reg, head_acc_next;
    logic                tail_acc_reg, tail_acc_next;

    logic [CNT_W-1:0]    room;
    logic [CNT_W-1:0]    n_calc;
    logic [CNT_W-1:0]    after_full;
    logic [BLK_W-1:0]    lo_calc, hi_calc, last_calc;
    logic                has_after_calc;
    logic [1:0]          head_code;

    logic                ram_we;
    logic [WORD_AW-1:0]  ram_waddr, ram_raddr;
    logic [WORD_DW-1:0]  ram_wdata, ram_rdata, rdata_m;
    logic [WORD_DW-1:0]  upd_word;
    logic                upd_head, upd_tail;
    upd_ctl_t            upd_ctl;

    sem_ram #(
        .ADDR_W (WORD_AW),
        .DATA_W (WORD_DW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign upd_ctl = '{
        first:     first_reg,
        prev:      prev_reg,
        last:      last_reg,
        after:     after_reg,
        has_prev:  has_prev_reg,
        has_after: has_after_reg,
        head_ok:   head_ok_reg
    };

    sem_word_upd u_upd (
        .ctl      (upd_ctl),
        .word     (word_reg),
        .old_word (rdata_m),
        .new_word (upd_word),
        .head_hit (upd_head),
        .tail_hit (upd_tail)
    );

    assign rdata_m   = rvalid_reg ? ram_rdata : '0;
    assign head_code = rdata_m[2*first_reg[WB_W-1:0] +: 2];
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;

    always_comb
    begin
        room           = CNT_W'(BLOCKS) - {1'b0, cmd.offset};
        n_calc         = (cmd.len < room) ? cmd.len : room;
        after_full     = {1'b0, cmd.offset} + n_calc;
        last_calc      = BLK_W'(after_full - 1'b1);
        has_after_calc = (after_full < CNT_W'(BLOCKS));
        lo_calc        = (cmd.offset != '0) ? (cmd.offset - 1'b1) : cmd.offset;
        hi_calc        = has_after_calc ? after_full[BLK_W-1:0] : last_calc;
    end

    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        first_next     = first_reg;
        prev_next      = prev_reg;
        last_next      = last_reg;
        after_next     = after_reg;
        has_prev_next  = has_prev_reg;
        has_after_next = has_after_reg;
        head_ok_next   = head_ok_reg;
        n_next         = n_reg;
        word_next      = word_reg;
        wend_next      = wend_reg;
        head_acc_next  = head_acc_reg;
        tail_acc_next  = tail_acc_reg;
        ram_we         = 1'b0;
        ram_waddr      = word_reg;
        ram_wdata      = upd_word;
        ram_raddr      = cmd.offset[BLK_W-1:WB_W];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    first_next     = cmd.offset;
                    prev_next      = lo_calc;
                    last_next      = last_calc;
                    after_next     = after_full[BLK_W-1:0];
                    has_prev_next  = (cmd.offset != '0);
                    has_after_next = has_after_calc;
                    n_next         = n_calc;
                    word_next      = lo_calc[BLK_W-1:WB_W];
                    wend_next      = hi_calc[BLK_W-1:WB_W];
                    head_acc_next  = 1'b0;
                    tail_acc_next  = 1'b0;
                    if (cmd.op == OP_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if (cmd.len == '0)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                    else
                    begin
                        state_next = ST_HEAD;
                    end
                end
            end
            ST_READ:
            begin
                done_next   = 1'b1;
                result_next = '0;
                result_next.block_code = head_code;
                state_next  = ST_IDLE;
            end
            ST_HEAD:
            begin
                head_ok_next = (head_code == CODE_INSIDE || head_code == CODE_END);
                ram_raddr    = word_reg;
                state_next   = ST_MOD;
            end
            ST_MOD:
            begin
                ram_we        = 1'b1;
                head_acc_next = head_acc_reg | upd_head;
                tail_acc_next = tail_acc_reg | upd_tail;
                ram_raddr     = word_reg + 1'b1;
                if (word_reg == wend_reg)
                begin
                    done_next   = 1'b1;
                    result_next = '{
                        block_code:    CODE_EMPTY,
                        head_trimmed:  head_acc_reg | upd_head,
                        tail_trimmed:  tail_acc_reg | upd_tail,
                        written_count: n_reg
                    };
                    state_next  = ST_IDLE;
                end
                else
                begin
                    word_next = word_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done_reg   <= 1'b0;
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            rvalid_reg <= valid_reg[ram_raddr];
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg    <= result_next;
        first_reg     <= first_next;
        prev_reg      <= prev_next;
        last_reg      <= last_next;
        after_reg     <= after_next;
        has_prev_reg  <= has_prev_next;
        has_after_reg <= has_after_next;
        head_ok_reg   <= head_ok_next;
        n_reg         <= n_next;
        word_reg      <= word_next;
        wend_reg      <= wend_next;
        head_acc_reg  <= head_acc_next;
        tail_acc_reg  <= tail_acc_next;
    end

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op == OP_READ) |-> ##2 done)
        else $error("Read transaction did not complete two cycles after acceptance.");

    a_write_only_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_MOD))
        else $error("Map RAM written outside the modify state.");

    a_word_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD) |-> (word_reg <= wend_reg))
        else $error("Word pointer ran past the last word of the insert.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.written_count <= CNT_W'(BLOCKS)))
        else $error("Written count exceeds the map size.");

    a_insert_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.written_count != '0) |-> (result.block_code == CODE_EMPTY))
        else $error("Insert result carries a block code.");

endmodule

`default_nettype wire

[test/tb_segment_extent_map_insert.sv]
// Self-checking testbench for segment_extent_map_insert: a directed table, then random
// insert and read transactions in bursts, each result checked against its fixed value or a
// block-map predictor. Depends on sem_pkg and the segment_extent_map_insert RTL.
`timescale 1ns / 1ps

module tb_segment_extent_map_insert;

    import sem_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 24;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        item_t   it;
        bit      fixed;
        result_t want;
    } dir_row_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   cmd;
    logic    done;
    result_t result;

    logic [1:0] model_map [BLOCKS];
    result_t    pending_results [$];
    dir_row_t   directed_rows [$];

    int cycle_count;
    int mismatches;
    int burst_left;
    int n_inserts;
    int n_reads;
    int n_clipped;
    int n_head_trims;
    int n_tail_trims;
    logic [6:0] last_first;

    segment_extent_map_insert dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic result_t make_result(logic [1:0] code, logic head, logic tail,
                                            logic [7:0] count);
        result_t r;
        r.block_code    = code;
        r.head_trimmed  = head;
        r.tail_trimmed  = tail;
        r.written_count = count;
        return r;
    endfunction

    function automatic item_t make_item(logic op, logic [6:0] offset, logic [7:0] len);
        item_t it;
        it.op     = op;
        it.offset = offset;
        it.len    = len;
        return it;
    endfunction

    // Applies one transaction to the shadow map and returns the result it should produce.
    function automatic result_t apply_segment_op(item_t it);
        result_t r;
        int first;
        int run;
        int after;
        logic [1:0] c;
        r = '0;
        first = int'(it.offset);
        if (it.op == OP_READ)
        begin
            r.block_code = model_map[first];
        end
        else if (it.len != 8'd0)
        begin
            run = (int'(it.len) < BLOCKS - first) ? int'(it.len) : BLOCKS - first;
            c = model_map[first];
            if ((c == CODE_INSIDE || c == CODE_END) && first > 0 &&
                model_map[first - 1] == CODE_INSIDE)
            begin
                model_map[first - 1] = CODE_END;
                r.head_trimmed = 1'b1;
            end
            model_map[first] = CODE_START;
            for (int i = 1; i + 1 < run; i++)
                model_map[first + i] = CODE_INSIDE;
            if (run > 1)
                model_map[first + run - 1] = CODE_END;
            after = first + run;
            if (after < BLOCKS)
            begin
                c = model_map[after];
                if (c == CODE_INSIDE || c == CODE_END)
                begin
                    model_map[after] = CODE_START;
                    r.tail_trimmed = 1'b1;
                end
            end
            r.written_count = 8'(run);
        end
        return r;
    endfunction

    task automatic add_row(logic op, logic [6:0] offset, logic [7:0] len, bit fixed,
                           result_t want);
        dir_row_t row;
        row.it    = make_item(op, offset, len);
        row.fixed = fixed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Drives one transaction, waits for it to be taken, records its expected result,
    // and ends the current burst with a gap when the burst is used up.
    task automatic issue(item_t it, bit fixed, result_t want);
        result_t predicted;
        start <= 1'b1;
        cmd   <= it;
        do @(posedge clk); while (busy !== 1'b0);
        predicted = apply_segment_op(it);
        pending_results.push_back(fixed ? want : predicted);
        if (it.op == OP_READ)
        begin
            n_reads++;
        end
        else
        begin
            n_inserts++;
            last_first = it.offset;
            if (int'(it.len) > BLOCKS - int'(it.offset))
                n_clipped++;
        end
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic item_t random_item();
        item_t it;
        int sel;
        sel = $urandom_range(0, 99);
        it.op = (sel < 40) ? OP_READ : OP_INSERT;
        if ($urandom_range(0, 9) < 3)
            it.offset = last_first + 7'($urandom_range(0, 24));
        else
            it.offset = 7'($urandom_range(0, BLOCKS - 1));
        sel = $urandom_range(0, 99);
        if (sel < 70)
            it.len = 8'($urandom_range(1, 16));
        else if (sel < 85)
            it.len = 8'($urandom_range(17, 128));
        else if (sel < 90)
            it.len = 8'd0;
        else
            it.len = 8'($urandom_range(129, 255));
        return it;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Unexpected result %p at cycle %0d.", result, cycle_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.block_code !== want.block_code ||
                    result.head_trimmed !== want.head_trimmed ||
                    result.tail_trimmed !== want.tail_trimmed ||
                    result.written_count !== want.written_count)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("Mismatch at cycle %0d: expected %p, got %p.",
                                 cycle_count, want, result);
                end
                if (result.head_trimmed === 1'b1)
                    n_head_trims++;
                if (result.tail_trimmed === 1'b1)
                    n_tail_trims++;
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cycle_count = 0;
        mismatches  = 0;
        burst_left  = 8;
        last_first  = '0;
        n_inserts   = 0;
        n_reads     = 0;
        n_clipped   = 0;
        n_head_trims = 0;
        n_tail_trims = 0;
        for (int i = 0; i < BLOCKS; i++)
            model_map[i] = CODE_EMPTY;

        add_row(OP_READ,   7'd0,   8'd0,   1'b1,
                make_result(CODE_EMPTY, 1'b0, 1'b0, 8'd0));
        add_row(OP_READ,   7'd127, 8'd255, 1'b1,
                make_result(CODE_EMPTY, 1'b0, 1'b0, 8'd0));
        add_row(OP_INSERT, 7'd0,   8'd0,   1'b1,
                make_result(CODE_EMPTY, 1'b0, 1'b0, 8'd0));
        add_row(OP_INSERT, 7'd0,   8'd1,   1'b1,
                make_result(CODE_EMPTY, 1'b0, 1'b0, 8'd1));
        add_row(OP_READ,   7'd0,   8'd0,   1'b1,
                make_result(CODE_START, 1'b0, 1'b0, 8'd0));
        add_row(OP_INSERT, 7'd10,  8'd20,  1'b1,
                make_result(CODE_EMPTY, 1'b0, 1'b0, 8'd20));
        add_row(OP_INSERT, 7'd15,  8'd3,   1'b1,
                make_result(CODE_EMPTY, 1'b1, 1'b1, 8'd3));
        add_row(OP_READ,   7'd14,  8'd0,   1'b1,
                make_result(CODE_END, 1'b0, 1'b0, 8'd0));
        add_row(OP_READ,   7'd18,  8'd0,   1'b1,
                make_result(CODE_START, 1'b0, 1'b0, 8'd0));
        add_row(OP_READ,   7'd16,  8'd0,   1'b0, '0);
        add_row(OP_INSERT, 7'd100, 8'd255, 1'b1,
                make_result(CODE_EMPTY, 1'b0, 1'b0, 8'd28));
        add_row(OP_INSERT, 7'd127, 8'd128, 1'b1,
                make_result(CODE_EMPTY, 1'b1, 1'b0, 8'd1));
        add_row(OP_READ,   7'd127, 8'd0,   1'b1,
                make_result(CODE_START, 1'b0, 1'b0, 8'd0));
        add_row(OP_INSERT, 7'd0,   8'd128, 1'b1,
                make_result(CODE_EMPTY, 1'b0, 1'b0, 8'd128));
        add_row(OP_READ,   7'd64,  8'd0,   1'b1,
                make_result(CODE_INSIDE, 1'b0, 1'b0, 8'd0));
        add_row(OP_READ,   7'd127, 8'd0,   1'b1,
                make_result(CODE_END, 1'b0, 1'b0, 8'd0));
        add_row(OP_INSERT, 7'd0,   8'd200, 1'b1,
                make_result(CODE_EMPTY, 1'b0, 1'b0, 8'd128));
        add_row(OP_INSERT, 7'd5,   8'd2,   1'b1,
                make_result(CODE_EMPTY, 1'b1, 1'b1, 8'd2));
        add_row(OP_INSERT, 7'd64,  8'd1,   1'b1,
                make_result(CODE_EMPTY, 1'b1, 1'b1, 8'd1));
        add_row(OP_INSERT, 7'd0,   8'd6,   1'b0, '0);
        add_row(OP_INSERT, 7'd120, 8'd7,   1'b0, '0);
        add_row(OP_READ,   7'd7,   8'd0,   1'b0, '0);
        add_row(OP_READ,   7'd126, 8'd0,   1'b0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[i])
            issue(directed_rows[i].it, directed_rows[i].fixed, directed_rows[i].want);
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            issue(random_item(), 1'b0, '0);
            if (n == RANDOM_ITEMS / 2)
                drain();
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d inserts (%0d clipped at map end) and %0d reads.",
                 n_inserts, n_clipped, n_reads);
        $display("Saw %0d head trims and %0d tail trims; %0d mismatches.",
                 n_head_trims, n_tail_trims, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
